>>> design/lcu_pkg.sv
// Package for the layered min-sum check update: shared codes, defaults and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package lcu_pkg;

  // Default sizes
  localparam int unsigned DEF_NUM_VARS         = 1024;
  localparam int unsigned DEF_NUM_EDGES        = 4096;
  localparam int unsigned DEF_MAX_CHECK_DEGREE = 32;
  localparam int unsigned DEF_LLR_BITS         = 8;

  // Fixed field widths
  localparam int unsigned VI_W     = 10;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned SCALE_W  = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Queue depths between front and back, and before the result ports
  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH = 2;

  // Register reset values (scale of about 0.825 in Q1.8)
  localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 9'd211;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET       = 2'd0,
    CFG_SCALE_SECOND = 2'd1,
    CFG_SCALE_FIRST  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EDGE,
    ST_SCALE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [SCALE_W-1:0]  scale_second;
    logic [SCALE_W-1:0]  scale_first;
  } cfg_t;

endpackage

>>> design/ldpc_layered_min_sum_check_update.sv
// Commands: a load is written to the posterior store as it is taken from the command queue; a
// read fetches the posterior, then waits for room in the result queue; a clear holds the back.
// Gathering: an edge is gathered by a store read, then a min update; at the check end the
// minima are scaled, then each edge is emitted by a buffer read, then a write that waits for room.
// Reset: control state clears at once, then a clearing pass zeroes the edge message store
// with full_o high; a clear command repeats that pass.
`timescale 1ns / 1ps
module ldpc_layered_min_sum_check_update
  import lcu_pkg::*;
#(
  parameter int unsigned NUM_VARS         = DEF_NUM_VARS,
  parameter int unsigned NUM_EDGES        = DEF_NUM_EDGES,
  parameter int unsigned MAX_CHECK_DEGREE = DEF_MAX_CHECK_DEGREE,
  parameter int unsigned LLR_BITS         = DEF_LLR_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SCALE_W-1:0]         cfg_data_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [1:0]                 command_i,
  input  logic [VI_W-1:0]            var_index_i,
  input  logic signed [LLR_BITS-1:0] llr_value_i,
  input  logic                       last_of_check_i,
  input  logic                       last_of_pass_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [VI_W-1:0]            out_var_index_o,
  output logic signed [LLR_BITS-1:0] posterior_llr_o,
  output logic signed [LLR_BITS-1:0] edge_message_o,
  output logic                       hard_bit_o,
  output logic                       last_o
);

  localparam int unsigned CMD_W = 2 + VI_W + LLR_BITS + 2;
  localparam int unsigned RES_W = VI_W + 2 * LLR_BITS + 2;

  // Fold the variable index into range by subtracting shifted copies of the count
  function automatic logic [VI_W-1:0] fold_index(input logic [VI_W-1:0] v);
    logic [VI_W-1:0] r;
    r = v;
    for (int k = VI_W - 1; k >= 0; k--) begin
      if ((longint'(NUM_VARS) << k) < (longint'(1) << VI_W)) begin
        if (VI_W'(longint'(NUM_VARS) << k) <= r) begin
          r = r - VI_W'(longint'(NUM_VARS) << k);
        end
      end
    end
    return r;
  endfunction

  cfg_t cfg_q;
  logic cmd_full, cmd_empty, cmd_pop, res_full, res_push, clearing;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic [RES_W-1:0] res_wdata, res_rdata;
  logic [1:0]                 hd_cmd;
  logic [VI_W-1:0]            hd_vi, r_vi;
  logic signed [LLR_BITS-1:0] hd_llr, r_post, r_msg;
  logic                       hd_ec, hd_ep, r_hard, r_last;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset       <= OFFSET_RST;
      cfg_q.scale_second <= SCALE_RST;
      cfg_q.scale_first  <= SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET:       cfg_q.offset       <= cfg_data_i[OFFSET_W-1:0];
        CFG_SCALE_SECOND: cfg_q.scale_second <= cfg_data_i;
        CFG_SCALE_FIRST:  cfg_q.scale_first  <= cfg_data_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // Front: fold indices and queue items, refuse them during a clearing pass
  assign full_o    = cmd_full || clearing;
  assign cmd_wdata = {command_i, fold_index(var_index_i), llr_value_i,
                      last_of_check_i, last_of_pass_i};

  lcu_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !clearing),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign {hd_cmd, hd_vi, hd_llr, hd_ec, hd_ep} = cmd_rdata;

  // Back: store access, gathering and emission
  lcu_engine #(
    .NUM_VARS         (NUM_VARS),
    .NUM_EDGES        (NUM_EDGES),
    .MAX_CHECK_DEGREE (MAX_CHECK_DEGREE),
    .LLR_BITS         (LLR_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_avail_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_e'(hd_cmd)),
    .vi_i        (hd_vi),
    .llr_i       (hd_llr),
    .end_check_i (hd_ec),
    .end_pass_i  (hd_ep),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_vi_o    (r_vi),
    .res_post_o  (r_post),
    .res_msg_o   (r_msg),
    .res_hard_o  (r_hard),
    .res_last_o  (r_last),
    .clearing_o  (clearing)
  );

  // Result queue
  assign res_wdata = {r_vi, r_post, r_msg, r_hard, r_last};

  lcu_fifo #(.WIDTH(RES_W), .DEPTH(RES_Q_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o)
  );

  assign {out_var_index_o, posterior_llr_o, edge_message_o, hard_bit_o, last_o} = res_rdata;

endmodule

>>> design/lcu_fifo.sv
// Small first-in first-out queue of flat words.
// Used between the front and the back and before the result ports; uses lcu_pkg.
`timescale 1ns / 1ps
module lcu_fifo
  import lcu_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = CMD_Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> design/lcu_engine.sv
// Back end of the check update: posterior and edge message stores, min-sum
// gathering and per-edge emission. Uses lcu_pkg.
`timescale 1ns / 1ps
module lcu_engine
  import lcu_pkg::*;
#(
  parameter int unsigned NUM_VARS         = DEF_NUM_VARS,
  parameter int unsigned NUM_EDGES        = DEF_NUM_EDGES,
  parameter int unsigned MAX_CHECK_DEGREE = DEF_MAX_CHECK_DEGREE,
  parameter int unsigned LLR_BITS         = DEF_LLR_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  // command queue head
  input  logic                       cmd_avail_i,
  output logic                       cmd_pop_o,
  input  cmd_e                       cmd_i,
  input  logic [VI_W-1:0]            vi_i,
  input  logic signed [LLR_BITS-1:0] llr_i,
  input  logic                       end_check_i,
  input  logic                       end_pass_i,
  // result queue tail
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output logic [VI_W-1:0]            res_vi_o,
  output logic signed [LLR_BITS-1:0] res_post_o,
  output logic signed [LLR_BITS-1:0] res_msg_o,
  output logic                       res_hard_o,
  output logic                       res_last_o,
  output logic                       clearing_o
);

  localparam int unsigned VA_W  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int unsigned EP_W  = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
  localparam int unsigned BW    = (MAX_CHECK_DEGREE > 1) ? $clog2(MAX_CHECK_DEGREE) : 1;
  localparam int unsigned DEG_W = $clog2(MAX_CHECK_DEGREE + 1);
  localparam int unsigned MW    = LLR_BITS + 1;
  localparam int unsigned MAGW  = LLR_BITS - 1;
  localparam int unsigned CW    = (MW > OFFSET_W) ? MW : OFFSET_W;
  localparam int unsigned PW    = MW + SCALE_W;
  localparam int unsigned SW    = LLR_BITS + 2;
  localparam logic [MAGW-1:0]        LLR_MAX  = '1;
  localparam logic [MW-1:0]          MIN_INIT = '1;
  localparam logic signed [SW-1:0]   SAT_HI   = SW'(signed'({1'b0, LLR_MAX}));
  localparam logic signed [SW-1:0]   SAT_LO   = -SAT_HI;

  // Scaled magnitude: max(m - offset, 0) * scale >> 8, saturated
  function automatic logic [MAGW-1:0] scale_mag(input logic [MW-1:0] m,
                                                input logic [OFFSET_W-1:0] off,
                                                input logic [SCALE_W-1:0] sc);
    logic [CW-1:0] me, oe;
    logic [MW-1:0] d;
    logic [PW-1:0] p;
    logic [PW-9:0] sh;
    me = CW'(m);
    oe = CW'(off);
    d  = (me > oe) ? MW'(me - oe) : '0;
    p  = PW'(d) * PW'(sc);
    sh = p[PW-1:8];
    return (sh > (PW-8)'(LLR_MAX)) ? LLR_MAX : MAGW'(sh);
  endfunction

  // Stores
  logic signed [LLR_BITS-1:0] post_mem [NUM_VARS];
  logic signed [LLR_BITS-1:0] em_mem   [NUM_EDGES];
  logic signed [MW-1:0]       cb_mem   [MAX_CHECK_DEGREE];
  logic [VI_W-1:0]            ib_mem   [MAX_CHECK_DEGREE];

  state_e state_q, state_d;
  logic [EP_W-1:0]  ptr_q, ptr_d, start_q, start_d, ea_q, ea_d, clr_q, clr_d;
  logic [DEG_W-1:0] deg_q, deg_d, j_q, j_d;
  logic [MW-1:0]    min1_q, min1_d, min2_q, min2_d;
  logic             par_q, par_d;
  logic [VI_W-1:0]  vi_q, vi_d;
  logic             ec_q, ec_d, ep_q, ep_d;
  logic [MAGW-1:0]  mag_min_q, mag_min_d, mag_oth_q, mag_oth_d;

  logic                       post_we, post_re;
  logic [VA_W-1:0]            post_wa, post_ra;
  logic signed [LLR_BITS-1:0] post_wd, post_rd_q;
  logic                       em_we, em_re;
  logic [EP_W-1:0]            em_wa;
  logic signed [LLR_BITS-1:0] em_wd, em_rd_q;
  logic                       buf_we, buf_re;
  logic signed [MW-1:0]       cb_rd_q;
  logic [VI_W-1:0]            ib_rd_q;

  logic signed [MW-1:0]       c_new, c_emit;
  logic [MW-1:0]              a_new, a_emit, hi;
  logic [MAGW-1:0]            mag;
  logic signed [LLR_BITS-1:0] msg;
  logic signed [SW-1:0]       sum;
  logic signed [LLR_BITS-1:0] post_new, load_sat;
  logic                       emit_last;

  // Gather datapath
  assign c_new = MW'(post_rd_q) - MW'(em_rd_q);
  assign a_new = c_new[MW-1] ? MW'(-c_new) : MW'(c_new);
  assign hi    = (a_new > min1_q) ? a_new : min1_q;

  // Emission datapath
  assign c_emit    = cb_rd_q;
  assign a_emit    = c_emit[MW-1] ? MW'(-c_emit) : MW'(c_emit);
  assign mag       = (a_emit == min1_q) ? mag_min_q : mag_oth_q;
  assign msg       = (par_q ^ c_emit[MW-1]) ? -LLR_BITS'({1'b0, mag})
                                            : LLR_BITS'({1'b0, mag});
  assign sum       = SW'(c_emit) + SW'(msg);
  assign post_new  = (sum > SAT_HI) ? LLR_BITS'(SAT_HI) :
                     (sum < SAT_LO) ? LLR_BITS'(SAT_LO) : LLR_BITS'(sum);
  assign emit_last = (j_q + 1'b1 == deg_q);

  // Saturate the most negative load value
  assign load_sat = (llr_i == {1'b1, {MAGW{1'b0}}}) ? -LLR_BITS'({1'b0, LLR_MAX}) : llr_i;

  assign clearing_o = (state_q == ST_CLEAR);

  // Next state and store controls
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    start_d   = start_q;
    ea_d      = ea_q;
    clr_d     = clr_q;
    deg_d     = deg_q;
    j_d       = j_q;
    min1_d    = min1_q;
    min2_d    = min2_q;
    par_d     = par_q;
    vi_d      = vi_q;
    ec_d      = ec_q;
    ep_d      = ep_q;
    mag_min_d = mag_min_q;
    mag_oth_d = mag_oth_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_vi_o   = vi_q;
    res_post_o = post_rd_q;
    res_msg_o  = '0;
    res_last_o = 1'b1;
    post_we = 1'b0;
    post_wa = VA_W'(vi_i);
    post_wd = load_sat;
    post_re = 1'b0;
    post_ra = VA_W'(vi_i);
    em_we   = 1'b0;
    em_wa   = clr_q;
    em_wd   = '0;
    em_re   = 1'b0;
    buf_we  = 1'b0;
    buf_re  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        // sweep the edge message store to zero
        em_we = 1'b1;
        if (clr_q == EP_W'(NUM_EDGES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_avail_i) begin
          cmd_pop_o = 1'b1;
          vi_d = vi_i;
          ec_d = end_check_i;
          ep_d = end_pass_i;
          unique case (cmd_i)
            CMD_LOAD: post_we = 1'b1;
            CMD_READ: begin
              post_re = 1'b1;
              state_d = ST_READ;
            end
            CMD_CLEAR: begin
              ptr_d   = '0;
              deg_d   = '0;
              min1_d  = MIN_INIT;
              min2_d  = MIN_INIT;
              par_d   = 1'b0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_EDGE: begin
              if (deg_q < DEG_W'(MAX_CHECK_DEGREE)) begin
                post_re = 1'b1;
                em_re   = 1'b1;
                if (deg_q == '0) begin
                  start_d = ptr_q;
                end
                state_d = ST_EDGE;
              end else if (end_check_i) begin
                state_d = ST_SCALE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_EDGE: begin
        // fold the contribution into the minima and parity
        buf_we = 1'b1;
        deg_d  = deg_q + 1'b1;
        ptr_d  = (ptr_q == EP_W'(NUM_EDGES - 1)) ? '0 : ptr_q + 1'b1;
        par_d  = par_q ^ c_new[MW-1];
        if (a_new < min1_q) begin
          min1_d = a_new;
        end
        if (hi < min2_q) begin
          min2_d = hi;
        end
        state_d = ec_q ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        mag_min_d = scale_mag(min2_q, cfg_i.offset, cfg_i.scale_second);
        mag_oth_d = scale_mag(min1_q, cfg_i.offset, cfg_i.scale_first);
        ea_d = start_q;
        j_d  = '0;
        if (deg_q == '0) begin
          min1_d  = MIN_INIT;
          min2_d  = MIN_INIT;
          par_d   = 1'b0;
          if (ep_q) begin
            ptr_d = '0;
          end
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        buf_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        res_vi_o   = ib_rd_q;
        res_post_o = post_new;
        res_msg_o  = msg;
        res_last_o = emit_last;
        post_wa    = VA_W'(ib_rd_q);
        post_wd    = post_new;
        em_wa      = ea_q;
        em_wd      = msg;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          post_we    = 1'b1;
          em_we      = 1'b1;
          j_d  = j_q + 1'b1;
          ea_d = (ea_q == EP_W'(NUM_EDGES - 1)) ? '0 : ea_q + 1'b1;
          if (emit_last) begin
            deg_d  = '0;
            min1_d = MIN_INIT;
            min2_d = MIN_INIT;
            par_d  = 1'b0;
            if (ep_q) begin
              ptr_d = '0;
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_hard_o = res_post_o[LLR_BITS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      clr_q   <= '0;
      deg_q   <= '0;
      j_q     <= '0;
      min1_q  <= MIN_INIT;
      min2_q  <= MIN_INIT;
      par_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
      deg_q   <= deg_d;
      j_q     <= j_d;
      min1_q  <= min1_d;
      min2_q  <= min2_d;
      par_q   <= par_d;
    end
  end

  // Hold payload of the current item
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    ea_q      <= ea_d;
    vi_q      <= vi_d;
    ec_q      <= ec_d;
    ep_q      <= ep_d;
    mag_min_q <= mag_min_d;
    mag_oth_q <= mag_oth_d;
  end

  // Posterior store
  always_ff @(posedge clk_i) begin
    if (post_we) begin
      post_mem[post_wa] <= post_wd;
    end
    if (post_re) begin
      post_rd_q <= post_mem[post_ra];
    end
  end

  // Edge message store
  always_ff @(posedge clk_i) begin
    if (em_we) begin
      em_mem[em_wa] <= em_wd;
    end
    if (em_re) begin
      em_rd_q <= em_mem[ptr_q];
    end
  end

  // Check buffers
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      cb_mem[deg_q[BW-1:0]] <= c_new;
      ib_mem[deg_q[BW-1:0]] <= vi_q;
    end
    if (buf_re) begin
      cb_rd_q <= cb_mem[j_q[BW-1:0]];
      ib_rd_q <= ib_mem[j_q[BW-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_deg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deg_q <= DEG_W'(MAX_CHECK_DEGREE))
    else $error("degree count beyond maximum");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_pop_o)
    else $error("item taken during clearing pass");
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (deg_q != '0 && j_q < deg_q))
    else $error("emission outside gathered edges");
  a_min_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min1_q <= min2_q)
    else $error("first minimum above second");
`endif

endmodule
